>>> rtl/lifo_rev_pkg.sv
// lifo_rev_pkg: shared types and codes for the lifo stack with block reverse
// used by lifo_rev_ctrl and lifo_stack_with_block_reverse, no dependencies
package lifo_rev_pkg;

  localparam int VALUE_W    = 32;
  localparam int LEVEL_W    = 7;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [1:0] {
    ACT_PUSH    = 2'd0,
    ACT_POP     = 2'd1,
    ACT_PEEK    = 2'd2,
    ACT_REVERSE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_LO,
    S_RD_HI,
    S_WR_LO,
    S_WR_HI,
    S_RESP
  } state_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    status_t                   status;
    logic [LEVEL_W-1:0]        fill_level;
    logic                      is_empty;
  } res_t;

endpackage

>>> rtl/lifo_stack_with_block_reverse.sv
// lifo_stack_with_block_reverse: bounded lifo of signed words with in-place reverse of the top
// depends on lifo_rev_pkg, lifo_rev_ram, lifo_rev_ctrl
//
// input stream: in_tuser carries the action (push, pop, peek, reverse), in_tdata the push
// value and the reverse count. every request gives exactly one transaction on the output
// stream: read value, fill level and empty flag in out_tdata, status in out_tuser.
// the entries live in one ram with a registered read port; the controller takes one
// request at a time.
// steps from acceptance to the result in the output register:
//   push, pop, peek: straight to the result (the ram access is issued in the accepting cycle)
//   reverse of n entries: floor(n / 2) swapped pairs, each swapped pair costs two ram
//   reads and two ram writes on the single read and single write port
//   reverse with n of 0 or 1, or any error: straight to the result, with no ram swaps
// push, pop and peek do not overlap: the next request waits for the last result to leave.
// the output register lets the controller take the next request while a result waits;
// with out_tready low the controller finishes that request and then holds its result
// until the register frees up, taking no further input.
// reset clears the stack length to zero; entry contents need no clearing.
module lifo_stack_with_block_reverse #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [lifo_rev_pkg::IN_DATA_W-1:0]    in_tdata,  // push_value, reverse_count, pad
  input  logic [1:0]                            in_tuser,  // action
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [lifo_rev_pkg::OUT_DATA_W-1:0]   out_tdata, // read_value, fill_level, is_empty
  output logic [1:0]                            out_tuser  // status
);
  import lifo_rev_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);

  logic               res_valid;
  logic               res_ready;
  res_t               res;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  lifo_rev_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lifo_rev_ctrl #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req_action (action_t'(in_tuser)),
    .req_value  (in_tdata[VALUE_W-1:0]),
    .req_count  (in_tdata[VALUE_W+LEVEL_W-1:VALUE_W]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.is_empty, out_res_r.fill_level, out_res_r.read_value};
  assign out_tuser  = out_res_r.status;

  // errors never return a word
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_res_r.status != ST_OK)) |-> (out_res_r.read_value == '0))
    else $error("error result carries a nonzero read value");

  // a blocked result stays pending in the controller
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> res_valid)
    else $error("controller dropped a pending result");

  // controller never takes a request while it still owns a result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !res_valid)
    else $error("input ready while a result is pending");

endmodule

>>> rtl/lifo_rev_ram.sv
// lifo_rev_ram: generic single write, single read ram with registered read
// no dependencies
module lifo_rev_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/lifo_rev_ctrl.sv
// lifo_rev_ctrl: request sequencer, stack pointer and swap engine for the stack ram
// depends on lifo_rev_pkg
module lifo_rev_ctrl #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   req_valid,
  output logic                                   req_ready,
  input  lifo_rev_pkg::action_t                  req_action,
  input  logic [lifo_rev_pkg::VALUE_W-1:0]       req_value,
  input  logic [lifo_rev_pkg::LEVEL_W-1:0]       req_count,
  output logic                                   res_valid,
  input  logic                                   res_ready,
  output lifo_rev_pkg::res_t                     res,
  output logic                                   ram_we,
  output logic [$clog2(STACK_DEPTH)-1:0]         ram_waddr,
  output logic [lifo_rev_pkg::VALUE_W-1:0]       ram_wdata,
  output logic                                   ram_re,
  output logic [$clog2(STACK_DEPTH)-1:0]         ram_raddr,
  input  logic [lifo_rev_pkg::VALUE_W-1:0]       ram_rdata
);
  import lifo_rev_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int NW = (CW > LEVEL_W) ? CW : LEVEL_W;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [AW-1:0]      lo_r, lo_nxt;
  logic [AW-1:0]      hi_r, hi_nxt;
  logic [VALUE_W-1:0] tmp_r, tmp_nxt;
  status_t            status_r, status_nxt;
  logic               mem_rd_r, mem_rd_nxt;

  logic          accept;
  logic          full;
  logic          empty;
  logic          n_over;
  logic          n_flip;
  logic [AW-1:0] lo_step;
  logic [AW-1:0] hi_step;
  logic          more_pairs;

  assign accept     = (state_r == S_IDLE) && req_valid;
  assign full       = (count_r == CW'(STACK_DEPTH));
  assign empty      = (count_r == '0);
  assign n_over     = (NW'(req_count) > NW'(count_r));
  assign n_flip     = (req_count > LEVEL_W'(1));
  assign lo_step    = lo_r + AW'(1);
  assign hi_step    = hi_r - AW'(1);
  assign more_pairs = (lo_step < hi_step);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          if ((req_action == ACT_REVERSE) && !n_over && n_flip) begin
            state_nxt = S_RD_LO;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_RD_LO: state_nxt = S_RD_HI;
      S_RD_HI: state_nxt = S_WR_LO;
      S_WR_LO: state_nxt = S_WR_HI;
      S_WR_HI: state_nxt = more_pairs ? S_RD_LO : S_RESP;
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_ready = 1'b0;
    res_valid = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = lo_r;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = lo_r;
    unique case (state_r)
      S_IDLE: begin
        req_ready = 1'b1;
        ram_waddr = AW'(count_r);
        ram_wdata = req_value;
        ram_raddr = AW'(count_r - CW'(1));
        if (req_valid) begin
          ram_we = (req_action == ACT_PUSH) && !full;
          ram_re = ((req_action == ACT_POP) || (req_action == ACT_PEEK)) && !empty;
        end
      end
      S_RD_LO: begin
        ram_re    = 1'b1;
        ram_raddr = lo_r;
      end
      S_RD_HI: begin
        ram_re    = 1'b1;
        ram_raddr = hi_r;
      end
      S_WR_LO: begin
        ram_we    = 1'b1;
        ram_waddr = lo_r;
        ram_wdata = ram_rdata;
      end
      S_WR_HI: begin
        ram_we    = 1'b1;
        ram_waddr = hi_r;
        ram_wdata = tmp_r;
      end
      S_RESP: res_valid = 1'b1;
      default: ;
    endcase
  end

  // pointer and result bookkeeping
  always_comb begin
    count_nxt  = count_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    tmp_nxt    = tmp_r;
    status_nxt = status_r;
    mem_rd_nxt = mem_rd_r;
    if (accept) begin
      status_nxt = ST_OK;
      mem_rd_nxt = 1'b0;
      unique case (req_action)
        ACT_PUSH: begin
          if (full) begin
            status_nxt = ST_OVER;
          end else begin
            count_nxt = count_r + CW'(1);
          end
        end
        ACT_POP: begin
          if (empty) begin
            status_nxt = ST_UNDER;
          end else begin
            count_nxt  = count_r - CW'(1);
            mem_rd_nxt = 1'b1;
          end
        end
        ACT_PEEK: begin
          if (empty) begin
            status_nxt = ST_UNDER;
          end else begin
            mem_rd_nxt = 1'b1;
          end
        end
        ACT_REVERSE: begin
          if (n_over) begin
            status_nxt = ST_UNDER;
          end
          lo_nxt = AW'(count_r - CW'(req_count));
          hi_nxt = AW'(count_r - CW'(1));
        end
        default: ;
      endcase
    end
    if (state_r == S_RD_HI) begin
      tmp_nxt = ram_rdata;
    end
    if (state_r == S_WR_HI) begin
      lo_nxt = lo_step;
      hi_nxt = hi_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      status_r <= ST_OK;
      mem_rd_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
      mem_rd_r <= mem_rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    tmp_r <= tmp_nxt;
  end

  assign res.read_value = mem_rd_r ? ram_rdata : '0;
  assign res.status     = status_r;
  assign res.fill_level = LEVEL_W'(count_r);
  assign res.is_empty   = empty;

endmodule
